>>> sv/krmc_pkg.sv
// Shared types and constants for the k-reach minimum-cost path block.
package krmc_pkg;

  // Field widths
  localparam int HEIGHT_W = 16;
  localparam int COST_W   = 32;
  localparam int JUMP_W   = 5;

  // Defaults and reset values
  localparam int                 MAX_REACH_DEF = 16;
  localparam logic [JUMP_W-1:0]  JUMP_RESET    = 5'd2;
  localparam logic [COST_W-1:0]  COST_MAX      = 32'hFFFF_FFFF;

  // Control from the sequencer to the cost unit
  typedef struct packed {
    logic start;  // clear the running minimum for a new item
    logic valid;  // history read data is present this cycle
  } krmc_ctl_t;

endpackage

>>> sv/k_reach_min_cost_path.sv
// Top level: sequencer over the height/cost history memory and the shared cost unit.
// Each input beat plans n = min(reach, positions held) history reads, with n = 0 for
//   a first position. The reads, candidates and minimum fold run, then the result is
//   registered once out_stall allows; a new item is taken only after that result is
//   registered. One history read and one candidate per cycle while the lookback runs.
// Reset (rst, synchronous): history empty, head at slot 0, max_jump back to 2,
//   no result pending. The history memory itself is not cleared.
module k_reach_min_cost_path #(
  parameter int MAX_REACH = krmc_pkg::MAX_REACH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [krmc_pkg::JUMP_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [krmc_pkg::HEIGHT_W-1:0] height,
  input  logic                          first_position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [krmc_pkg::COST_W-1:0]   best_cost
);

  localparam int IDX_W  = (MAX_REACH > 1) ? $clog2(MAX_REACH) : 1;
  localparam int CNT_W  = $clog2(MAX_REACH + 1);
  localparam int RCH_W  = (CNT_W > krmc_pkg::JUMP_W) ? CNT_W : krmc_pkg::JUMP_W;
  localparam int WORD_W = krmc_pkg::HEIGHT_W + krmc_pkg::COST_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]                   state;
  logic [krmc_pkg::JUMP_W-1:0]  max_jump;
  logic [IDX_W-1:0]             head;
  logic [IDX_W-1:0]             ptr;
  logic [CNT_W-1:0]             seen;
  logic [CNT_W-1:0]             n_reg;
  logic [CNT_W-1:0]             issued;
  logic                         rd_valid;
  logic [krmc_pkg::HEIGHT_W-1:0] cur_h;

  logic                         in_beat;
  logic                         out_free;
  logic                         issue;
  logic                         fin_go;
  logic [RCH_W-1:0]             reach;
  logic [RCH_W-1:0]             seen_eff;
  logic [CNT_W-1:0]             n_next;
  logic [IDX_W-1:0]             head_dec;
  logic [IDX_W-1:0]             ptr_dec;
  logic [IDX_W-1:0]             head_inc;
  logic [krmc_pkg::COST_W-1:0]  result;

  logic [WORD_W-1:0]            rdata;
  krmc_pkg::krmc_ctl_t          ctl;
  logic                         unit_busy;
  logic [krmc_pkg::COST_W-1:0]  unit_best;

  // Handshake decode
  assign in_stall = (state != S_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign issue    = (state == S_RUN) && (issued != n_reg);
  assign fin_go   = (state == S_FIN) && out_free;

  // Clamp the jump limit and size the lookback for this item
  always_comb begin
    reach = RCH_W'(max_jump);
    if (max_jump == '0) begin
      reach = RCH_W'(1);
    end else if (RCH_W'(max_jump) > RCH_W'(MAX_REACH)) begin
      reach = RCH_W'(MAX_REACH);
    end
    seen_eff = first_position ? '0 : RCH_W'(seen);
    n_next   = (reach < seen_eff) ? CNT_W'(reach) : CNT_W'(seen_eff);
  end

  // Circular slot arithmetic
  assign head_dec = (head == '0) ? IDX_W'(MAX_REACH - 1) : (head - IDX_W'(1));
  assign ptr_dec  = (ptr == '0)  ? IDX_W'(MAX_REACH - 1) : (ptr - IDX_W'(1));
  assign head_inc = (head == IDX_W'(MAX_REACH - 1)) ? '0 : (head + IDX_W'(1));

  assign result = (n_reg == '0) ? '0 : unit_best;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_jump <= krmc_pkg::JUMP_RESET;
    end else if (cfg_we) begin
      max_jump <= cfg_wdata;
    end
  end

  // Sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      seen     <= '0;
      issued   <= '0;
      n_reg    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            n_reg  <= n_next;
            issued <= '0;
            if (first_position) begin
              seen <= '0;
            end
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (issue) begin
            issued <= issued + CNT_W'(1);
          end else if (!rd_valid && !unit_busy) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            head <= head_inc;
            if (seen < CNT_W'(MAX_REACH)) begin
              seen <= seen + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Capture current height and walk the read pointer back
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cur_h <= height;
      ptr   <= head_dec;
    end else if (issue) begin
      ptr <= ptr_dec;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      best_cost <= result;
    end
  end

  // History memory: height in the upper bits, cost in the lower bits
  krmc_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_REACH)
  ) u_hist (
    .clk  (clk),
    .we   (fin_go),
    .waddr(head),
    .wdata({cur_h, result}),
    .raddr(ptr),
    .rdata(rdata)
  );

  // Shared candidate unit
  assign ctl.start = in_beat;
  assign ctl.valid = rd_valid;

  krmc_cost_unit u_cost (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cur_height (cur_h),
    .prev_height(rdata[WORD_W-1:krmc_pkg::COST_W]),
    .prev_cost  (rdata[krmc_pkg::COST_W-1:0]),
    .busy       (unit_busy),
    .best       (unit_best)
  );

`ifndef SYNTHESIS
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issued <= n_reg)
    else $error("lookback issued more reads than planned");

  a_first_no_lookback: assert property (@(posedge clk) disable iff (rst)
    (in_beat && first_position) |=> (n_reg == '0))
    else $error("first position planned a lookback");

  a_lookback_in_history: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (n_reg <= seen))
    else $error("lookback reaches past the held history");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    seen <= CNT_W'(MAX_REACH))
    else $error("position count exceeds history depth");

  a_fin_idle_pipe: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (!rd_valid && !unit_busy))
    else $error("result taken with candidates still in flight");
`endif

endmodule

>>> sv/krmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module krmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/krmc_cost_unit.sv
// Shared candidate unit: absolute height difference, saturating add, running minimum.
module krmc_cost_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  krmc_pkg::krmc_ctl_t           ctl,
  input  logic [krmc_pkg::HEIGHT_W-1:0] cur_height,
  input  logic [krmc_pkg::HEIGHT_W-1:0] prev_height,
  input  logic [krmc_pkg::COST_W-1:0]   prev_cost,
  output logic                          busy,
  output logic [krmc_pkg::COST_W-1:0]   best
);

  logic [krmc_pkg::HEIGHT_W-1:0] diff;
  logic [krmc_pkg::COST_W:0]     sum;
  logic [krmc_pkg::COST_W-1:0]   cand_next;
  logic [krmc_pkg::COST_W-1:0]   cand;
  logic                          cand_valid;

  // Form one saturated candidate from the history entry
  always_comb begin
    diff = (cur_height >= prev_height) ? (cur_height - prev_height)
                                       : (prev_height - cur_height);
    sum  = {1'b0, prev_cost}
         + {{(krmc_pkg::COST_W + 1 - krmc_pkg::HEIGHT_W){1'b0}}, diff};
    cand_next = sum[krmc_pkg::COST_W] ? krmc_pkg::COST_MAX
                                      : sum[krmc_pkg::COST_W-1:0];
  end

  // Track candidate stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else begin
      cand_valid <= ctl.valid;
    end
  end

  // Register candidate, then fold into the minimum
  always_ff @(posedge clk) begin
    cand <= cand_next;
    if (ctl.start) begin
      best <= krmc_pkg::COST_MAX;
    end else if (cand_valid && (cand < best)) begin
      best <= cand;
    end
  end

  assign busy = cand_valid;

endmodule
